FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of the scaler block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("scaler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scaler assertion failed");

`endif

FILE: sv/lbs_pkg.sv
// Shared types, constants and blend functions of the letterbox scaler.
// No dependencies.
`timescale 1ns / 1ps

package lbs_pkg;

    localparam int COL_W      = 13;
    localparam int ROW_W      = 12;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 24;
    localparam int WT_W       = 9;
    localparam int FRAC_W     = 16;
    localparam int Q_W        = 17;
    localparam int NUM_W      = 31;
    localparam int DEN_W      = 14;
    localparam int SCALE_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 24;
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = 5;
    localparam int CNT_W      = 6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_SCALE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VERT_SCALE    = 3'd6;

    // Item kinds
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Sample modes
    localparam logic MODE_POINT    = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    localparam logic [SCALE_W-1:0] SCALE_ONE = 17'h10000;

    typedef struct packed {
        logic             op;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] rgb;   // red 23..16, green 15..8, blue 7..0
    } item_t;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            in_picture;
    } result_t;

    // One channel: (a*(256-w) + b*w) / 256, rounded
    function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b,
                                                 input logic [WT_W-1:0] w);
        logic [16:0] acc;
        acc = ({9'd0, a} * (17'd256 - {8'd0, w})) + ({9'd0, b} * {8'd0, w}) + 17'd128;
        return acc[15:8];
    endfunction

    function automatic logic [PIX_W-1:0] blend_px(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b,
                                                  input logic [WT_W-1:0] w);
        return {blend_ch(a[23:16], b[23:16], w),
                blend_ch(a[15:8], b[15:8], w),
                blend_ch(a[7:0], b[7:0], w)};
    endfunction

endpackage

FILE: sv/letterbox_bilinear_scaler.sv
// Letterbox bilinear scaler top level: frame store, coordinate pipeline, output FIFO.
// Depends on lbs_pkg, lbs_ram and lbs_div_pipe.
`timescale 1ns / 1ps

// The block takes one item per clock while s_tready is high, loads and samples
// alike, and returns one result per sample item; a load item gives no result and
// is written to the store in pipeline order, so a sample sees every load accepted
// before it. The two 17-stage coordinate dividers make up most of the pipeline;
// the throughput is set by the four-bank frame store (row and column parity),
// which delivers all four bilinear neighbours in one read. A 32-item output FIFO
// absorbs back-pressure: s_tready drops only when 32 samples are outstanding.
// The store is not cleared at reset; sample only pixels that have been loaded.

module letterbox_bilinear_scaler
    import lbs_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // col, row, red_in, green_in, blue_in, zero pad
    input  logic [0:0]            s_tuser,   // operation
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // red_out, green_out, blue_out
    output logic [0:0]            m_tuser,   // in_picture
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int XW     = $clog2(MAX_SRC_WIDTH);
    localparam int YW     = $clog2(MAX_SRC_HEIGHT);
    localparam int SWW    = $clog2(MAX_SRC_WIDTH + 1);
    localparam int SHW    = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int PXW    = Q_W + SWW;
    localparam int PYW    = Q_W + SHW;
    localparam int HALF_W = (MAX_SRC_WIDTH + 1) / 2;
    localparam int HALF_H = (MAX_SRC_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    typedef struct packed {
        item_t item;
        logic  outside;
    } side_t;

    // ---------------- configuration registers ----------------
    logic               mode_reg;
    logic [9:0]         src_w_reg;
    logic [9:0]         src_h_reg;
    logic [12:0]        tgt_w_reg;
    logic [11:0]        tgt_h_reg;
    logic [SCALE_W-1:0] hscale_reg;
    logic [SCALE_W-1:0] vscale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_BILINEAR;
            src_w_reg  <= 10'd512;
            src_h_reg  <= 10'd512;
            tgt_w_reg  <= 13'd512;
            tgt_h_reg  <= 12'd512;
            hscale_reg <= SCALE_ONE;
            vscale_reg <= SCALE_ONE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SAMPLE_MODE:   mode_reg   <= cfg_data[0];
                CFG_SOURCE_WIDTH:  src_w_reg  <= cfg_data[9:0];
                CFG_SOURCE_HEIGHT: src_h_reg  <= cfg_data[9:0];
                CFG_TARGET_WIDTH:  tgt_w_reg  <= cfg_data[12:0];
                CFG_TARGET_HEIGHT: tgt_h_reg  <= cfg_data[11:0];
                CFG_HORIZ_SCALE:   hscale_reg <= cfg_data;
                CFG_VERT_SCALE:    vscale_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // normalized sizes
    logic [12:0]    tw_n;
    logic [12:0]    th_n;
    logic [SWW-1:0] sw_n;
    logic [SHW-1:0] sh_n;

    assign tw_n = (tgt_w_reg == '0) ? 13'd1 : tgt_w_reg;
    assign th_n = (tgt_h_reg == '0) ? 13'd1 : {1'b0, tgt_h_reg};
    assign sw_n = SWW'((src_w_reg == '0) ? 1 :
                       (32'(src_w_reg) > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : 32'(src_w_reg));
    assign sh_n = SHW'((src_h_reg == '0) ? 1 :
                       (32'(src_h_reg) > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : 32'(src_h_reg));

    // N = 65536*w + (2*pos - w)*scale, with scale clamped to SCALE_ONE
    function automatic logic signed [31:0] axis_num(input logic [12:0] pos,
                                                   input logic [12:0] w,
                                                   input logic [SCALE_W-1:0] scale);
        logic [SCALE_W-1:0] s;
        logic signed [15:0] d;
        logic signed [33:0] n;
        s = (scale > SCALE_ONE) ? SCALE_ONE : scale;
        d = $signed({2'b00, pos, 1'b0}) - $signed({3'b000, w});
        n = 34'(d) * $signed({17'd0, s}) + $signed({5'd0, w, 16'd0});
        return n[31:0];
    endfunction

    // ---------------- input acceptance and credit ----------------
    logic             in_fire;
    logic             out_fire;
    item_t            in_item;
    logic [CNT_W-1:0] pend_reg;
    logic [CNT_W-1:0] pend_next;

    assign s_tready = (pend_reg < CNT_W'(FIFO_DEPTH));
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign in_item  = '{op: s_tuser[0], col: s_tdata[12:0], row: s_tdata[24:13],
                        rgb: {s_tdata[32:25], s_tdata[40:33], s_tdata[48:41]}};

    always_comb
    begin
        pend_next = pend_reg;
        if (in_fire && (in_item.op == OP_SAMPLE))
        begin
            pend_next = pend_next + CNT_W'(1);
        end
        if (out_fire)
        begin
            pend_next = pend_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // ---------------- stage A: axis products ----------------
    logic               a_valid_reg;
    item_t              a_item_reg;
    logic signed [31:0] a_nu_reg;
    logic signed [31:0] a_nv_reg;

    always_ff @(posedge clk)
    begin
        a_item_reg <= in_item;
        a_nu_reg   <= axis_num(in_item.col, tw_n, hscale_reg);
        a_nv_reg   <= axis_num({1'b0, in_item.row}, th_n, vscale_reg);
    end

    // ---------------- stage B: letterbox test, divider operands ----------------
    logic             b_valid_reg;
    side_t            b_side_reg;
    logic [NUM_W-1:0] b_num_u_reg;
    logic [NUM_W-1:0] b_num_v_reg;
    logic [DEN_W-1:0] b_den_u_reg;
    logic [DEN_W-1:0] b_den_v_reg;
    logic             out_u;
    logic             out_v;

    assign out_u = a_nu_reg[31] || (a_nu_reg[30:0] > {1'b0, tw_n, 17'd0});
    assign out_v = a_nv_reg[31] || (a_nv_reg[30:0] > {1'b0, th_n, 17'd0});

    always_ff @(posedge clk)
    begin
        b_side_reg  <= '{item: a_item_reg, outside: out_u || out_v};
        b_num_u_reg <= a_nu_reg[30:0];
        b_num_v_reg <= a_nv_reg[30:0];
        b_den_u_reg <= {tw_n, 1'b0};
        b_den_v_reg <= {th_n, 1'b0};
    end

    // ---------------- dividers and matching side line ----------------
    logic [Q_W-1:0] quo_u;
    logic [Q_W-1:0] quo_v;
    logic [Q_W-1:0] line_valid_reg;
    side_t          line_side_reg [Q_W];

    lbs_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div_u (
        .clk (clk),
        .num (b_num_u_reg),
        .den (b_den_u_reg),
        .quo (quo_u)
    );

    lbs_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div_v (
        .clk (clk),
        .num (b_num_v_reg),
        .den (b_den_v_reg),
        .quo (quo_v)
    );

    always_ff @(posedge clk)
    begin
        line_side_reg[0] <= b_side_reg;
        for (int k = 1; k < Q_W; k++)
        begin
            line_side_reg[k] <= line_side_reg[k-1];
        end
    end

    // ---------------- stage C: source positions ----------------
    logic           c_valid_reg;
    side_t          c_side_reg;
    logic [PXW-1:0] c_pu_reg;
    logic [PYW-1:0] c_pv_reg;

    always_ff @(posedge clk)
    begin
        c_side_reg <= line_side_reg[Q_W-1];
        c_pu_reg   <= PXW'(quo_u) * PXW'(sw_n);
        c_pv_reg   <= PYW'(quo_v) * PYW'(sh_n);
    end

    // ---------------- stage D: indices, clamp, flip, weights ----------------
    logic            d_valid_reg;
    side_t           d_side_reg;
    logic [XW-1:0]   d_x1_reg;
    logic [XW-1:0]   d_x2_reg;
    logic [YW-1:0]   d_y1_reg;
    logic [YW-1:0]   d_y2_reg;
    logic [WT_W-1:0] d_wx_reg;
    logic [WT_W-1:0] d_wy_reg;

    logic [SWW:0]    ix_raw;
    logic [SWW:0]    ix1;
    logic [SWW:0]    ix2;
    logic [SHW:0]    iy_raw;
    logic [SHW:0]    iy1;
    logic [SHW:0]    iy2;
    logic [16:0]     wx_sum;
    logic [16:0]     wy_sum;

    always_comb
    begin
        ix_raw = c_pu_reg[PXW-1:FRAC_W];
        ix1 = (ix_raw >= {1'b0, sw_n}) ? ({1'b0, sw_n} - (SWW+1)'(1)) : ix_raw;
        ix2 = ((ix1 + (SWW+1)'(1)) >= {1'b0, sw_n}) ? ix1 : (ix1 + (SWW+1)'(1));
        iy_raw = c_pv_reg[PYW-1:FRAC_W];
        iy1 = (iy_raw >= {1'b0, sh_n}) ? ({1'b0, sh_n} - (SHW+1)'(1)) : iy_raw;
        iy2 = ((iy1 + (SHW+1)'(1)) >= {1'b0, sh_n}) ? iy1 : (iy1 + (SHW+1)'(1));
        wx_sum = {1'b0, c_pu_reg[FRAC_W-1:0]} + 17'd128;
        wy_sum = {1'b0, c_pv_reg[FRAC_W-1:0]} + 17'd128;
    end

    always_ff @(posedge clk)
    begin
        d_side_reg <= c_side_reg;
        d_x1_reg   <= XW'(ix1);
        d_x2_reg   <= XW'(ix2);
        // vertical flip
        d_y1_reg   <= YW'({1'b0, sh_n} - (SHW+1)'(1) - iy1);
        d_y2_reg   <= YW'({1'b0, sh_n} - (SHW+1)'(1) - iy2);
        d_wx_reg   <= wx_sum[16:8];
        d_wy_reg   <= wy_sum[16:8];
    end

    // ---------------- stage E: banked frame store ----------------
    logic             e_valid_reg;
    side_t            e_side_reg;
    logic [WT_W-1:0]  e_wx_reg;
    logic [WT_W-1:0]  e_wy_reg;
    logic             e_x1p_reg;
    logic             e_x2p_reg;
    logic             e_y1p_reg;
    logic             e_y2p_reg;
    logic [PIX_W-1:0] bank_rd [4];
    logic             ld_en;
    logic [AW-1:0]    ld_addr;

    assign ld_en   = d_valid_reg && (d_side_reg.item.op == OP_LOAD) &&
                     (32'(d_side_reg.item.col) < MAX_SRC_WIDTH) &&
                     (32'(d_side_reg.item.row) < MAX_SRC_HEIGHT);
    assign ld_addr = AW'((32'(d_side_reg.item.row) >> 1) * HALF_W +
                         (32'(d_side_reg.item.col) >> 1));

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [XW-1:0] xs;
        logic [YW-1:0] ys;
        logic [AW-1:0] rd_addr;
        logic          wr_en;

        // pick the neighbour of this bank's parity
        assign xs      = (d_x1_reg[0] == b[0]) ? d_x1_reg : d_x2_reg;
        assign ys      = (d_y1_reg[0] == b[1]) ? d_y1_reg : d_y2_reg;
        assign rd_addr = AW'((32'(ys) >> 1) * HALF_W + (32'(xs) >> 1));
        assign wr_en   = ld_en && (d_side_reg.item.col[0] == b[0]) &&
                         (d_side_reg.item.row[0] == b[1]);

        lbs_ram #(.WIDTH(PIX_W), .DEPTH(BANK_DEPTH), .ADDR_W(AW)) u_ram (
            .clk     (clk),
            .wr_en   (wr_en),
            .wr_addr (ld_addr),
            .wr_data (d_side_reg.item.rgb),
            .rd_addr (rd_addr),
            .rd_data (bank_rd[b])
        );
    end

    always_ff @(posedge clk)
    begin
        e_side_reg <= d_side_reg;
        e_wx_reg   <= d_wx_reg;
        e_wy_reg   <= d_wy_reg;
        e_x1p_reg  <= d_x1_reg[0];
        e_x2p_reg  <= d_x2_reg[0];
        e_y1p_reg  <= d_y1_reg[0];
        e_y2p_reg  <= d_y2_reg[0];
    end

    // ---------------- stage F: vertical blends ----------------
    logic             f_valid_reg;
    side_t            f_side_reg;
    logic [WT_W-1:0]  f_wx_reg;
    logic [PIX_W-1:0] f_point_reg;
    logic [PIX_W-1:0] f_left_reg;
    logic [PIX_W-1:0] f_right_reg;
    logic [PIX_W-1:0] p11;
    logic [PIX_W-1:0] p12;
    logic [PIX_W-1:0] p21;
    logic [PIX_W-1:0] p22;

    assign p11 = bank_rd[{e_y1p_reg, e_x1p_reg}];
    assign p12 = bank_rd[{e_y2p_reg, e_x1p_reg}];
    assign p21 = bank_rd[{e_y1p_reg, e_x2p_reg}];
    assign p22 = bank_rd[{e_y2p_reg, e_x2p_reg}];

    always_ff @(posedge clk)
    begin
        f_side_reg  <= e_side_reg;
        f_wx_reg    <= e_wx_reg;
        f_point_reg <= p11;
        f_left_reg  <= blend_px(p11, p12, e_wy_reg);
        f_right_reg <= blend_px(p21, p22, e_wy_reg);
    end

    // ---------------- stage G: horizontal blend, result ----------------
    logic [PIX_W-1:0] g_pix;
    result_t          g_res;
    logic             fifo_wr;

    assign g_pix   = (mode_reg == MODE_POINT) ? f_point_reg :
                     blend_px(f_left_reg, f_right_reg, f_wx_reg);
    assign g_res   = f_side_reg.outside ? '0 :
                     '{red: g_pix[23:16], green: g_pix[15:8], blue: g_pix[7:0],
                       in_picture: 1'b1};
    assign fifo_wr = f_valid_reg && (f_side_reg.item.op == OP_SAMPLE);

    // valid bits of all stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            line_valid_reg <= '0;
            c_valid_reg    <= 1'b0;
            d_valid_reg    <= 1'b0;
            e_valid_reg    <= 1'b0;
            f_valid_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg    <= in_fire;
            b_valid_reg    <= a_valid_reg;
            line_valid_reg <= {line_valid_reg[Q_W-2:0], b_valid_reg};
            c_valid_reg    <= line_valid_reg[Q_W-1];
            d_valid_reg    <= c_valid_reg;
            e_valid_reg    <= d_valid_reg;
            f_valid_reg    <= e_valid_reg;
        end
    end

    // ---------------- output FIFO and output register ----------------
    result_t            fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]   fifo_cnt_reg;
    logic               fifo_rd;
    logic               m_valid_reg;
    result_t            m_res_reg;

    assign fifo_rd = (fifo_cnt_reg != '0) && (!m_valid_reg || m_tready);

    always_ff @(posedge clk)
    begin
        if (fifo_wr)
        begin
            fifo_mem[wr_ptr_reg] <= g_res;
        end
        if (fifo_rd)
        begin
            m_res_reg <= fifo_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (fifo_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (fifo_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + CNT_W'(fifo_wr) - CNT_W'(fifo_rd);
            if (fifo_rd)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.blue, m_res_reg.green, m_res_reg.red};
    assign m_tuser  = m_res_reg.in_picture;

endmodule

FILE: sv/lbs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: sv/lbs_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
// No dependencies; quotient must fit in Q_W bits.
`timescale 1ns / 1ps

module lbs_div_pipe #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 14,
    parameter int Q_W   = 17
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    localparam int CW = (NUM_W > DEN_W + Q_W - 1) ? NUM_W : DEN_W + Q_W - 1;

    logic [NUM_W-1:0] rem_reg [Q_W-1];
    logic [DEN_W-1:0] den_reg [Q_W-1];
    logic [Q_W-1:0]   quo_reg [Q_W];

    for (genvar j = 0; j < Q_W; j++)
    begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   quo_in;
        logic [CW-1:0]    trial;
        logic             fits;

        if (j == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        // compare against divisor shifted to this bit
        assign trial = CW'(den_in) << (Q_W - 1 - j);
        assign fits  = (CW'(rem_in) >= trial);

        always_ff @(posedge clk)
        begin
            quo_reg[j] <= fits ? (quo_in | (Q_W'(1) << (Q_W - 1 - j))) : quo_in;
        end

        if (j < Q_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[j] <= fits ? NUM_W'(CW'(rem_in) - trial) : rem_in;
                den_reg[j] <= den_in;
            end
        end
    end

    assign quo = quo_reg[Q_W-1];

endmodule

FILE: sv/lbs_checker.sv
// Port-level checker for the letterbox scaler, bound to the top level.
// Depends on lbs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lbs_checker
    import lbs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic [0:0]            s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [0:0]            m_tuser,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // samples accepted but not yet delivered
    logic [CNT_W-1:0] pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg
                      + CNT_W'(s_tvalid && s_tready && (s_tuser[0] == OP_SAMPLE))
                      - CNT_W'(m_tvalid && m_tready);
        end
    end

    // letterbox results are black
    `LBS_ASSERT_IMP(a_black, clk, rst_n, m_tvalid && !m_tuser[0], m_tdata == '0)
    // no result without an outstanding sample
    `LBS_ASSERT_IMP(a_no_orphan, clk, rst_n, m_tvalid, pend_reg != '0)
    // input is held off once the result buffer could be full
    `LBS_ASSERT_IMP(a_credit, clk, rst_n, pend_reg >= CNT_W'(FIFO_DEPTH), !s_tready)
    // a stalled result holds
    `LBS_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    logic unused_cfg;
    assign unused_cfg = cfg_valid ^ cfg_ready ^ (^cfg_index) ^ (^cfg_data) ^ (^s_tdata);

endmodule

bind letterbox_bilinear_scaler lbs_checker u_lbs_checker (.*);
